// ----- hw/rtl/acl_pkg.sv -----
// ----------------------------------------------------------------------------
// acl_pkg
// Shared types and constants of the area-coverage line upscaler.
// ----------------------------------------------------------------------------
package acl_pkg;

  localparam int PIX_W       = 8;
  localparam int RATIO_W     = 20;
  localparam int LENGTH_W    = 12;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 1;
  localparam int MAX_RESULTS = 18;
  localparam int RES_W       = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SCALE_RATIO = 1'b0,
    CFG_OUT_LENGTH  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             line_end_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             run_last;
    logic             line_end_out;
  } out_t;

endpackage

// ----- hw/rtl/acl_mac.sv -----
// ----------------------------------------------------------------------------
// acl_mac
// Shared weight multiplier: registered floor(coef * sample / 2^FRAC_BITS).
// ----------------------------------------------------------------------------
module acl_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic [FRAC_BITS:0]          coef,
  input  logic [acl_pkg::PIX_W-1:0]   sample,
  output logic [acl_pkg::PIX_W-1:0]   term
);
  import acl_pkg::*;

  logic [FRAC_BITS+PIX_W:0] product;

  assign product = coef * {{(FRAC_BITS+1){1'b0}}, sample};

  always_ff @(posedge clk) begin
    term <= product[FRAC_BITS+PIX_W-1:FRAC_BITS];
  end

endmodule

// ----- hw/rtl/acl_out_stage.sv -----
// ----------------------------------------------------------------------------
// acl_out_stage
// Output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module acl_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  acl_pkg::out_t load_data,
  output logic          ready,
  output logic          valid,
  output acl_pkg::out_t data,
  input  logic          stall
);
  import acl_pkg::*;

  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      data <= load_data;
    end
  end

endmodule

// ----- hw/rtl/area_coverage_line_upscaler_core.sv -----
// ----------------------------------------------------------------------------
// area_coverage_line_upscaler_core
// One-axis area-coverage RGB upscaler: copies, boundary blend, row padding.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-----------------------------
//  in       | input     | in_valid/stall   | in_data   (red/green/blue, line end)
//  out      | output    | out_valid/stall  | out_data  (rgb, run_last, line end)
//  cfg      | input     | cfg_write        | cfg_index, cfg_data
//
//  An item issues its k copies, after a blend result when it has one;
//  the blend runs six products through one shared multiplier, one per cycle.
//  The next item is taken only once the previous item's results are issued.
//  Out stall holds the sequencer at its next result; the output register lets
//  the last result wait while the next item is taken.
//  Reset clears the sequencer, coverage and row state; config resets to
//  ratio 1.0 and length 1.
// ----------------------------------------------------------------------------
module area_coverage_line_upscaler_core #(
  parameter int MAX_LINE  = 2048,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  acl_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output acl_pkg::out_t                    out_data,
  input  logic                             cfg_write,
  input  logic [acl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [acl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import acl_pkg::*;

  localparam int DW  = $clog2(MAX_LINE + 1);
  localparam int LW  = (DW > LENGTH_W) ? DW : LENGTH_W;
  localparam int CW  = ((FRAC_BITS + 1 > RATIO_W) ? FRAC_BITS + 1 : RATIO_W) + 1;
  localparam int KW  = CW - FRAC_BITS;
  localparam logic [CW-1:0]        ONE      = CW'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0]   ONE_COEF = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [LW-1:0]        MAX_LEN  = LW'(MAX_LINE);
  localparam logic [2:0]           MIX_LAST = 3'd6;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_MIX    = 6'b000100,
    S_BLEND  = 6'b001000,
    S_RUN    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                state;
  logic [RATIO_W-1:0]    scale_ratio;
  logic [LENGTH_W-1:0]   out_length;
  in_t                   item;
  logic [3*PIX_W-1:0]    held;
  logic [FRAC_BITS-1:0]  coverage_left;
  logic [FRAC_BITS-1:0]  alpha;
  logic [KW-1:0]         kcnt;
  logic [DW-1:0]         done;
  logic [RES_W-1:0]      nres;
  logic                  row_start;
  logic [2:0]            step;
  logic [PIX_W-1:0]      mix_r;
  logic [PIX_W-1:0]      mix_g;
  logic [PIX_W-1:0]      mix_b;

  logic [LW-1:0]         length_ext;
  logic [DW-1:0]         len_eff;
  logic [CW-1:0]         ratio_ext;
  logic [CW-1:0]         r_eff;
  logic [CW-1:0]         cov;
  logic [FRAC_BITS:0]    coef;
  logic [PIX_W-1:0]      sample;
  logic [PIX_W-1:0]      term;
  logic [2:0]            step_prev;
  logic                  stage_ready;
  logic                  can_run;
  logic                  emit;
  logic [KW-1:0]         k_after;
  logic [RES_W-1:0]      n_after;
  logic [DW-1:0]         done_after;
  logic                  more;
  out_t                  result;

  // effective configuration
  assign length_ext = LW'(out_length);
  always_comb begin
    if (length_ext == '0) begin
      len_eff = DW'(1);
    end else if (length_ext > MAX_LEN) begin
      len_eff = DW'(MAX_LEN);
    end else begin
      len_eff = DW'(length_ext);
    end
  end

  assign ratio_ext = CW'(scale_ratio);
  assign r_eff     = (ratio_ext < ONE) ? ONE : ratio_ext;
  assign cov       = row_start ? r_eff : (r_eff + CW'(coverage_left) - ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_ratio <= RATIO_W'(65536);
      out_length  <= LENGTH_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SCALE_RATIO: scale_ratio <= cfg_data[RATIO_W-1:0];
        CFG_OUT_LENGTH:  out_length  <= cfg_data[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // blend operand select: even steps weight the held pixel, odd the new one
  always_comb begin
    coef = step[0] ? (ONE_COEF - {1'b0, alpha}) : {1'b0, alpha};
    case (step[2:1])
      2'd0:    sample = step[0] ? item.red_in   : held[3*PIX_W-1:2*PIX_W];
      2'd1:    sample = step[0] ? item.green_in : held[2*PIX_W-1:PIX_W];
      default: sample = step[0] ? item.blue_in  : held[PIX_W-1:0];
    endcase
  end

  acl_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk    (clk),
    .coef   (coef),
    .sample (sample),
    .term   (term)
  );

  assign step_prev = step - 3'd1;

  // result lookahead
  assign can_run = (nres < RES_W'(MAX_RESULTS)) && (done < len_eff) &&
                   ((kcnt != '0) || item.line_end_in);
  assign emit    = stage_ready && ((state == S_BLEND) || ((state == S_RUN) && can_run));
  assign k_after = ((state == S_RUN) && (kcnt != '0)) ? kcnt - KW'(1) : kcnt;
  assign n_after    = nres + RES_W'(1);
  assign done_after = done + DW'(1);
  assign more = (n_after < RES_W'(MAX_RESULTS)) && (done_after < len_eff) &&
                (item.line_end_in || (k_after != '0));

  always_comb begin
    if (state == S_BLEND) begin
      result.red_out   = mix_r;
      result.green_out = mix_g;
      result.blue_out  = mix_b;
    end else begin
      result.red_out   = item.red_in;
      result.green_out = item.green_in;
      result.blue_out  = item.blue_in;
    end
    result.run_last     = !more;
    result.line_end_out = (done_after == len_eff) || (!more && item.line_end_in);
  end

  acl_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_data (result),
    .ready     (stage_ready),
    .valid     (out_valid),
    .data      (out_data),
    .stall     (out_stall)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      held          <= '0;
      coverage_left <= '0;
      kcnt          <= '0;
      done          <= '0;
      nres          <= '0;
      row_start     <= 1'b1;
      step          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          kcnt          <= cov[CW-1:FRAC_BITS];
          coverage_left <= cov[FRAC_BITS-1:0];
          nres          <= '0;
          step          <= '0;
          if (row_start) begin
            done      <= '0;
            row_start <= 1'b0;
            state     <= S_RUN;
          end else if (done < len_eff) begin
            state <= S_MIX;
          end else begin
            state <= S_RUN;
          end
        end
        S_MIX: begin
          step <= step + 3'd1;
          if (step == MIX_LAST) begin
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (emit) begin
            nres  <= n_after;
            done  <= done_after;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!can_run) begin
            state <= S_FINISH;
          end else if (emit) begin
            kcnt <= k_after;
            nres <= n_after;
            done <= done_after;
          end
        end
        S_FINISH: begin
          held  <= {item.red_in, item.green_in, item.blue_in};
          state <= S_IDLE;
          if (item.line_end_in) begin
            row_start     <= 1'b1;
            coverage_left <= '0;
            done          <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item <= in_data;
    end
    if (state == S_SETUP) begin
      alpha <= coverage_left;
    end
    if (state == S_MIX && step != 3'd0) begin
      case (step_prev[2:1])
        2'd0:    mix_r <= step_prev[0] ? mix_r + term : term;
        2'd1:    mix_g <= step_prev[0] ? mix_g + term : term;
        default: mix_b <= step_prev[0] ? mix_b + term : term;
      endcase
    end
  end

  // checks
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while not stalled afterward");

  a_result_budget: assert property (@(posedge clk) disable iff (rst)
    nres <= RES_W'(MAX_RESULTS))
    else $error("result count exceeds budget");

  a_emit_into_free_stage: assert property (@(posedge clk) disable iff (rst)
    emit |-> (stage_ready && (state == S_BLEND || state == S_RUN)))
    else $error("result issued into a busy output register");

  a_mix_to_blend: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX && step == MIX_LAST) |=> (state == S_BLEND))
    else $error("blend sequence did not complete");

endmodule

// ----- dv/acl_upscale_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// acl_upscale_checker
// Watches the config, pixel-in and pixel-out ports of the line upscaler. It
// keeps its own copy of the scale ratio, row length, held pixel and coverage,
// and works out the output pixels that every input transfer must produce.
// Every output transfer is compared field by field with the oldest predicted
// pixel.
// ----------------------------------------------------------------------------
module acl_upscale_checker #(
  parameter int MAX_LINE  = 2048,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  acl_pkg::in_t                     in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  acl_pkg::out_t                    out_data,
  input  logic                             cfg_write,
  input  logic [acl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [acl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               pending,
  output int                               failures,
  output int                               pixels_seen,
  output int                               results_seen,
  output int                               rows_seen
);
  import acl_pkg::*;

  localparam int unsigned ONE = 1 << FRAC_BITS;

  int unsigned ratio_reg;
  int unsigned length_reg;
  logic [23:0] held_rgb;
  int unsigned coverage;
  int unsigned done_count;
  bit          row_fresh;

  out_t        upscaled_q[$];
  out_t        step_out[MAX_RESULTS];
  int          step_n;

  initial begin
    pending      = 0;
    failures     = 0;
    pixels_seen  = 0;
    results_seen = 0;
    rows_seen    = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    failures++;
  endtask

  function automatic logic [7:0] blend_channel(input int unsigned a, input logic [7:0] h,
                                               input logic [7:0] p);
    longint unsigned wa;
    longint unsigned t1;
    longint unsigned t2;
    longint unsigned s;
    wa = a;
    t1 = (wa * h) >> FRAC_BITS;
    t2 = ((ONE - wa) * p) >> FRAC_BITS;
    s  = t1 + t2;
    return s[7:0];
  endfunction

  task emit_pixel(input logic [23:0] rgb, input int unsigned len);
    out_t px;
    px           = '0;
    px.red_out   = rgb[23:16];
    px.green_out = rgb[15:8];
    px.blue_out  = rgb[7:0];
    done_count++;
    px.line_end_out = (done_count == len);
    step_out[step_n] = px;
    step_n++;
  endtask

  task predict_pixel(input in_t px);
    int unsigned len;
    int unsigned r;
    int unsigned cov;
    logic [23:0] rgb;
    logic [23:0] mix;
    len = length_reg;
    if (len < 1) len = 1;
    if (len > MAX_LINE) len = MAX_LINE;
    r = (ratio_reg < ONE) ? ONE : ratio_reg;
    rgb = {px.red_in, px.green_in, px.blue_in};
    step_n = 0;

    if (row_fresh) begin
      done_count = 0;
      cov        = r;
      row_fresh  = 1'b0;
    end else begin
      if (done_count < len && step_n < MAX_RESULTS) begin
        mix = {blend_channel(coverage, held_rgb[23:16], rgb[23:16]),
               blend_channel(coverage, held_rgb[15:8], rgb[15:8]),
               blend_channel(coverage, held_rgb[7:0], rgb[7:0])};
        emit_pixel(mix, len);
      end
      cov = r + coverage - ONE;
    end

    while (cov >= ONE) begin
      if (done_count < len && step_n < MAX_RESULTS) emit_pixel(rgb, len);
      cov -= ONE;
    end

    held_rgb = rgb;
    coverage = cov;

    // pad the row with copies of its last pixel
    if (px.line_end_in) begin
      while (done_count < len && step_n < MAX_RESULTS) emit_pixel(rgb, len);
      if (step_n > 0) step_out[step_n-1].line_end_out = 1'b1;
      row_fresh  = 1'b1;
      coverage   = 0;
      done_count = 0;
      rows_seen++;
    end

    if (step_n > 0) step_out[step_n-1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) upscaled_q.push_back(step_out[i]);
  endtask

  task check_result(input out_t got);
    out_t want;
    results_seen++;
    if (upscaled_q.size() == 0) begin
      report_mismatch("result with nothing expected", got, 0);
    end else begin
      want = upscaled_q.pop_front();
      if (got.red_out != want.red_out)
        report_mismatch("red_out", got.red_out, want.red_out);
      if (got.green_out != want.green_out)
        report_mismatch("green_out", got.green_out, want.green_out);
      if (got.blue_out != want.blue_out)
        report_mismatch("blue_out", got.blue_out, want.blue_out);
      if (got.run_last != want.run_last)
        report_mismatch("run_last", got.run_last, want.run_last);
      if (got.line_end_out != want.line_end_out)
        report_mismatch("line_end_out", got.line_end_out, want.line_end_out);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ratio_reg  = ONE;
      length_reg = 1;
      held_rgb   = '0;
      coverage   = 0;
      done_count = 0;
      row_fresh  = 1'b1;
      upscaled_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_SCALE_RATIO) ratio_reg = cfg_data[RATIO_W-1:0];
        else if (cfg_index == CFG_OUT_LENGTH) length_reg = cfg_data[LENGTH_W-1:0];
      end
      if (in_valid && !in_stall) begin
        pixels_seen++;
        predict_pixel(in_data);
      end
      if (out_valid && !out_stall) check_result(out_data);
    end
    pending = upscaled_q.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the line upscaler through directed rows (extreme pixels, ratios
// below one and near sixteen, zero and oversized row lengths, overrun, single
// pixel rows, cut-short padding) and then random rows under random register
// settings, with random gaps on the pixel input and random output stall.
// Prediction and comparison live in acl_upscale_checker.
// ----------------------------------------------------------------------------
module testbench;
  import acl_pkg::*;

  localparam int MAX_LINE     = 2048;
  localparam int FRAC_BITS    = 16;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int RANDOM_ITEMS = 220;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 2000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_write;
  cfg_index_t           cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int pending;
  int failures;
  int pixels_seen;
  int results_seen;
  int rows_seen;

  int items_sent;
  int settings_used;
  int stall_left;
  int idle_cycles;
  bit in_burst;
  bit out_burst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  area_coverage_line_upscaler_core #(
    .MAX_LINE  (MAX_LINE),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  acl_upscale_checker #(
    .MAX_LINE  (MAX_LINE),
    .FRAC_BITS (FRAC_BITS)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .failures     (failures),
    .pixels_seen  (pixels_seen),
    .results_seen (results_seen),
    .rows_seen    (rows_seen)
  );

  // draw a new stall after every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) stall_left = out_burst ? 0 : $urandom_range(0, 4);
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic in_t pixel(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic line_end);
    in_t px;
    px.red_in      = r;
    px.green_in    = g;
    px.blue_in     = b;
    px.line_end_in = line_end;
    return px;
  endfunction

  task send_pixel(input in_t px);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // wait out every predicted pixel plus the tail of an item with no output
  task settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task apply_setting(input logic [CFG_DATA_W-1:0] ratio, input logic [CFG_DATA_W-1:0] length);
    write_reg(CFG_SCALE_RATIO, ratio);
    write_reg(CFG_OUT_LENGTH, length);
    settings_used++;
  endtask

  task pick_setting();
    logic [CFG_DATA_W-1:0] ratio;
    logic [CFG_DATA_W-1:0] length;
    case ($urandom_range(0, 9))
      0:       ratio = CFG_DATA_W'($urandom_range(0, ONE - 1));
      1:       ratio = 20'hFFFFF;
      2:       ratio = CFG_DATA_W'(ONE);
      3:       ratio = CFG_DATA_W'($urandom_range(ONE, 20'hFFFFF));
      default: ratio = CFG_DATA_W'($urandom_range(ONE, 4 * ONE));
    endcase
    case ($urandom_range(0, 9))
      0:       length = '0;
      1:       length = CFG_DATA_W'($urandom_range(MAX_LINE, 4095));
      default: length = CFG_DATA_W'($urandom_range(1, 24));
    endcase
    apply_setting(ratio, length);
  endtask

  task send_random_row();
    int n;
    bit line_end;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      line_end = (i == n - 1);
      // break the row framing now and then
      if ($urandom_range(0, 9) == 0) line_end = 1'($urandom_range(0, 1));
      send_pixel(pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                       PIX_W'($urandom_range(0, 255)), line_end));
    end
  endtask

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_SCALE_RATIO;
    cfg_data      = '0;
    out_stall     = 1'b0;
    stall_left    = 0;
    items_sent    = 0;
    settings_used = 1;
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // reset defaults: single-pixel rows, row full after one output
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_pixel(pixel(8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(pixel(8'hAA, 8'h55, 8'hAA, 1'b1));
    settle();

    // ratio below one and zero length
    apply_setting(20'h00000, 20'd0);
    send_pixel(pixel(8'h12, 8'h34, 8'h56, 1'b1));
    settle();

    // half-pixel blends between extremes, padded row
    apply_setting(20'h18000, 20'd8);
    send_pixel(pixel(8'hFF, 8'h00, 8'hFF, 1'b0));
    send_pixel(pixel(8'h00, 8'hFF, 8'h00, 1'b0));
    send_pixel(pixel(8'h80, 8'h7F, 8'h01, 1'b0));
    send_pixel(pixel(8'hFE, 8'h01, 8'h80, 1'b1));
    settle();

    // largest ratio, oversized length: result budget and cut-short padding
    apply_setting(20'hFFFFF, 20'hFFF);
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(pixel(8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(pixel(8'hFF, 8'h00, 8'hFF, 1'b1));
    settle();

    // ratio just above one, full-width row
    apply_setting(20'h10001, CFG_DATA_W'(MAX_LINE));
    send_pixel(pixel(8'h55, 8'hAA, 8'h55, 1'b0));
    send_pixel(pixel(8'hAA, 8'h55, 8'hAA, 1'b1));
    settle();

    // overrun past the row length
    apply_setting(20'h2C000, 20'd5);
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(pixel(8'h01, 8'h02, 8'h03, 1'b0));
    send_pixel(pixel(8'h80, 8'h80, 8'h80, 1'b0));
    send_pixel(pixel(8'hC0, 8'hC0, 8'hC0, 1'b1));
    settle();

    while (items_sent < 18 + RANDOM_ITEMS) begin
      pick_setting();
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) send_random_row();
      settle();
    end

    $display("Sent %0d pixels in %0d rows under %0d register settings;",
             pixels_seen, rows_seen, settings_used);
    $display("checked %0d upscaled pixels, %0d mismatches.", results_seen, failures);
    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
